// File: hdl/assert_macros.svh
// Assertion macros shared by the substring match finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/fsmf_pkg.sv
// Shared constants and types of the substring match finder.
package fsmf_pkg;

	localparam int PATTERN_MAX = 32;
	localparam longint unsigned TEXT_MAX = 64'd65535;

	localparam int BYTE_W = 8;
	localparam int IDX_W = 5;
	localparam int LEN_W = 6;
	localparam int POS_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 1'd1;

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT = 1'b1;

	typedef struct packed {
		logic shift;
		logic clear;
		logic [BYTE_W-1:0] data;
	} cell_ctrl_t;

	typedef struct packed {
		logic [POS_W-1:0] match_position;
		logic found;
		logic overflow;
	} result_t;

endpackage

// File: hdl/first_substring_match_finder.sv
// Top level of the substring match finder: window cells, match tracking, result buffer.
//
// Usage: pattern bytes are written as input beats with op = 0 at pattern_index.
// Text bytes follow as beats with op = 1, one byte per beat; last marks the final
// text byte of a string. The configuration channel writes pattern_length (index 0)
// and start_offset (index 1); cfg_ready is always high.
// Each text beat shifts a window of PATTERN_MAX byte cells and compares the newest
// pattern_length bytes against the pattern in the same cycle, so one input beat is
// accepted every clock cycle while the result buffer is not full.
// A last text beat yields one result beat, match_position, found and overflow,
// valid in the cycle after that beat is accepted unless an earlier result waits.
// Results go through a two-entry buffer: input beats keep flowing while one result
// waits, and in_ready drops only while two results wait on a stalled receiver.
// Reset clears the window, the text counter, the match tracking, both registers
// and the result buffer. Pattern bytes are not cleared and must be written before
// use. After each result the stream state returns to its reset value.
`include "assert_macros.svh"
module first_substring_match_finder #(
	parameter int PATTERN_MAX = fsmf_pkg::PATTERN_MAX,
	parameter longint unsigned TEXT_MAX = fsmf_pkg::TEXT_MAX
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [fsmf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsmf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic op,
	input  logic [fsmf_pkg::IDX_W-1:0] pattern_index,
	input  logic [fsmf_pkg::BYTE_W-1:0] data_byte,
	input  logic last,
	output logic out_valid,
	input  logic out_ready,
	output logic [fsmf_pkg::POS_W-1:0] match_position,
	output logic found,
	output logic overflow
);

	localparam int BW = fsmf_pkg::BYTE_W;
	localparam int CNT_W = $clog2(TEXT_MAX + 64'd1);
	localparam int CMP_W = (CNT_W > fsmf_pkg::POS_W) ? CNT_W : fsmf_pkg::POS_W;
	localparam int SH_W = $clog2(PATTERN_MAX + 1);

	logic [fsmf_pkg::LEN_W-1:0] pattern_length_q;
	logic [fsmf_pkg::POS_W-1:0] start_offset_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] first_q;
	logic seen_q;
	logic ovf_q;

	logic in_fire;
	logic text_fire;
	logic pat_fire;
	logic buf_full;
	logic [fsmf_pkg::LEN_W-1:0] len;
	logic [SH_W-1:0] sh;
	logic [BW*PATTERN_MAX-1:0] rev_flat;
	logic [BW*PATTERN_MAX-1:0] aligned_flat;
	logic [BW-1:0] win [PATTERN_MAX];
	logic [BW-1:0] pat [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] hits;
	logic window_match;
	fsmf_pkg::cell_ctrl_t ctrl;

	logic [CNT_W-1:0] count_n;
	logic [CNT_W-1:0] first_n;
	logic [CNT_W-1:0] pos;
	logic seen_n;
	logic ovf_n;
	fsmf_pkg::result_t res;
	fsmf_pkg::result_t res_out;

	assign cfg_ready = 1'b1;
	assign in_ready = !buf_full;
	assign in_fire = in_valid && in_ready;
	assign text_fire = in_fire && (op == fsmf_pkg::OP_TEXT);
	assign pat_fire = in_fire && (op == fsmf_pkg::OP_PATTERN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= '0;
			start_offset_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				fsmf_pkg::REG_PATTERN_LENGTH: begin
					pattern_length_q <= cfg_data[fsmf_pkg::LEN_W-1:0];
				end
				fsmf_pkg::REG_START_OFFSET: begin
					start_offset_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign len = (int'(pattern_length_q) > PATTERN_MAX) ? fsmf_pkg::LEN_W'(PATTERN_MAX)
		: pattern_length_q;
	assign sh = SH_W'(PATTERN_MAX) - SH_W'(len);

	assign ctrl.shift = text_fire;
	assign ctrl.clear = text_fire && last;
	assign ctrl.data = data_byte;

	// Cell k faces pattern byte len-1-k: the pattern, reversed, slides down by
	// PATTERN_MAX - len byte positions.
	assign aligned_flat = rev_flat >> {sh, 3'b000};

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		assign rev_flat[BW*k +: BW] = pat[PATTERN_MAX-1-k];

		fsmf_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.prev_byte   ((k == 0) ? data_byte : win[(k == 0) ? 0 : k-1]),
			.pat_we      (pat_fire && (int'(pattern_index) == k)),
			.aligned_pat (aligned_flat[BW*k +: BW]),
			.active      (int'(len) > k),
			.win_byte    (win[k]),
			.pat_byte    (pat[k]),
			.hit         (hits[k])
		);
	end

	assign window_match = &hits;

	always_comb begin
		count_n = count_q;
		first_n = first_q;
		seen_n = seen_q;
		ovf_n = ovf_q;
		pos = count_q + 1'b1 - CNT_W'(len);
		if (count_q < CNT_W'(TEXT_MAX)) begin
			count_n = count_q + 1'b1;
			if ((len != '0) && (CMP_W'(count_n) >= CMP_W'(len)) && !seen_q
				&& (CMP_W'(pos) >= CMP_W'(start_offset_q)) && window_match) begin
				seen_n = 1'b1;
				first_n = pos;
			end
		end else begin
			ovf_n = 1'b1;
		end

		if (len == '0) begin
			res.match_position = '0;
			res.found = 1'b1;
		end else if (seen_n) begin
			res.match_position = fsmf_pkg::POS_W'(first_n);
			res.found = 1'b1;
		end else begin
			res.match_position = fsmf_pkg::POS_W'(count_n);
			res.found = 1'b0;
		end
		res.overflow = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			first_q <= '0;
			seen_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (text_fire) begin
			if (last) begin
				count_q <= '0;
				first_q <= '0;
				seen_q <= 1'b0;
				ovf_q <= 1'b0;
			end else begin
				count_q <= count_n;
				first_q <= first_n;
				seen_q <= seen_n;
				ovf_q <= ovf_n;
			end
		end
	end

	fsmf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (text_fire && last),
		.din       (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (res_out)
	);

	assign match_position = res_out.match_position;
	assign found = res_out.found;
	assign overflow = res_out.overflow;

	`ASSERT_NEXT(a_stream_cleared, clk, arst_n, text_fire && last, (count_q == '0) && !seen_q && !ovf_q)
	`ASSERT_IMPLIES(a_ovf_at_limit, clk, arst_n, ovf_q, count_q == CNT_W'(TEXT_MAX))
	`ASSERT_IMPLIES(a_first_in_text, clk, arst_n, seen_q, first_q < count_q)

endmodule

// File: hdl/fsmf_cell.sv
// One window cell: a text byte, a pattern byte and their comparison.
module fsmf_cell (
	input  logic clk,
	input  logic arst_n,
	input  fsmf_pkg::cell_ctrl_t ctrl,
	input  logic [fsmf_pkg::BYTE_W-1:0] prev_byte,
	input  logic pat_we,
	input  logic [fsmf_pkg::BYTE_W-1:0] aligned_pat,
	input  logic active,
	output logic [fsmf_pkg::BYTE_W-1:0] win_byte,
	output logic [fsmf_pkg::BYTE_W-1:0] pat_byte,
	output logic hit
);

	logic [fsmf_pkg::BYTE_W-1:0] win_q;
	logic [fsmf_pkg::BYTE_W-1:0] pat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctrl.clear) begin
			win_q <= '0;
		end else if (ctrl.shift) begin
			win_q <= prev_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_q <= ctrl.data;
		end
	end

	// The compare sees the window as it stands after this beat's shift.
	assign hit = !active || (prev_byte == aligned_pat);
	assign win_byte = win_q;
	assign pat_byte = pat_q;

endmodule

// File: hdl/fsmf_out_buf.sv
// Two-entry result buffer between the match logic and the result channel.
`include "assert_macros.svh"
module fsmf_out_buf (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  fsmf_pkg::result_t din,
	output logic full,
	output logic out_valid,
	input  logic out_ready,
	output fsmf_pkg::result_t dout
);

	fsmf_pkg::result_t head_q;
	fsmf_pkg::result_t skid_q;
	logic head_v_q;
	logic skid_v_q;
	logic pop;

	assign pop = head_v_q && out_ready;
	assign full = head_v_q && skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				head_v_q <= push;
			end
		end else if (push) begin
			if (head_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				head_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= skid_v_q ? skid_q : din;
		end else if (push && !head_v_q) begin
			head_q <= din;
		end
		if (push && head_v_q && !pop) begin
			skid_q <= din;
		end
	end

	assign out_valid = head_v_q;
	assign dout = head_q;

	`ASSERT_IMPLIES(a_skid_behind_head, clk, arst_n, skid_v_q, head_v_q)
	`ASSERT_NEXT(a_push_lands, clk, arst_n, push && !head_v_q, head_v_q)
	`ASSERT_NEXT(a_last_pop_empties, clk, arst_n, pop && !skid_v_q && !push, !head_v_q)

endmodule

// File: verif/tb_first_substring_match_finder.sv
// Self-checking testbench for the first substring match finder, with its scoreboard class.
module tb_first_substring_match_finder;
	timeunit 1ns;
	timeprecision 1ps;

	class search_scoreboard;
		logic [fsmf_pkg::BYTE_W-1:0] pat_mem [fsmf_pkg::PATTERN_MAX];
		logic [fsmf_pkg::BYTE_W-1:0] recent [fsmf_pkg::PATTERN_MAX];
		logic [fsmf_pkg::LEN_W-1:0] len_reg;
		logic [fsmf_pkg::POS_W-1:0] offset_reg;
		int unsigned bytes_counted;
		int unsigned hit_pos;
		bit hit_found;
		bit saturated;
		fsmf_pkg::result_t pending_reports[$];
		int unsigned mismatches;
		int unsigned reports_checked;
		int unsigned beats_seen;

		function new();
			foreach (pat_mem[i]) pat_mem[i] = '0;
			len_reg = '0;
			offset_reg = '0;
			mismatches = 0;
			reports_checked = 0;
			beats_seen = 0;
			restart_text();
		endfunction

		function void restart_text();
			foreach (recent[i]) recent[i] = '0;
			bytes_counted = 0;
			hit_pos = 0;
			hit_found = 1'b0;
			saturated = 1'b0;
		endfunction

		function void write_register(logic [fsmf_pkg::CFG_IDX_W-1:0] idx,
			logic [fsmf_pkg::CFG_DATA_W-1:0] data);
			if (idx == fsmf_pkg::REG_PATTERN_LENGTH) begin
				len_reg = data[fsmf_pkg::LEN_W-1:0];
			end else begin
				offset_reg = data;
			end
		endfunction

		// Advances the search by one input beat and queues the report a last text byte yields.
		function void note_beat(logic o, logic [fsmf_pkg::IDX_W-1:0] idx,
			logic [fsmf_pkg::BYTE_W-1:0] b, logic l);
			int unsigned used;
			int unsigned i;
			bit same;
			fsmf_pkg::result_t rep;
			beats_seen++;
			if (o == fsmf_pkg::OP_PATTERN) begin
				pat_mem[idx] = b;
				return;
			end
			for (i = fsmf_pkg::PATTERN_MAX - 1; i > 0; i--) recent[i] = recent[i-1];
			recent[0] = b;
			used = (len_reg > fsmf_pkg::PATTERN_MAX) ? fsmf_pkg::PATTERN_MAX : len_reg;
			if (bytes_counted < fsmf_pkg::TEXT_MAX) begin
				bytes_counted++;
				if (used > 0 && bytes_counted >= used && !hit_found
					&& bytes_counted - used >= offset_reg) begin
					same = 1'b1;
					for (i = 0; i < used; i++)
						if (pat_mem[i] != recent[used-1-i]) same = 1'b0;
					if (same) begin
						hit_found = 1'b1;
						hit_pos = bytes_counted - used;
					end
				end
			end else begin
				saturated = 1'b1;
			end
			if (!l) return;
			if (used == 0) begin
				rep.match_position = '0;
				rep.found = 1'b1;
			end else if (hit_found) begin
				rep.match_position = hit_pos[fsmf_pkg::POS_W-1:0];
				rep.found = 1'b1;
			end else begin
				rep.match_position = bytes_counted[fsmf_pkg::POS_W-1:0];
				rep.found = 1'b0;
			end
			rep.overflow = saturated;
			pending_reports.push_back(rep);
			restart_text();
		endfunction

		function void check_report(fsmf_pkg::result_t got);
			fsmf_pkg::result_t want;
			reports_checked++;
			if (pending_reports.size() == 0) begin
				log_mismatch("result beat with nothing outstanding", '0, got);
				return;
			end
			want = pending_reports.pop_front();
			if (got.match_position !== want.match_position || got.found !== want.found
				|| got.overflow !== want.overflow)
				log_mismatch("result beat differs", want, got);
		endfunction

		function void log_mismatch(string what, fsmf_pkg::result_t want,
			fsmf_pkg::result_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t %s: expected position %0d found %0b overflow %0b, got %0d %0b %0b",
					$time, what, want.match_position, want.found, want.overflow,
					got.match_position, got.found, got.overflow);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [fsmf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fsmf_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic op;
	logic [fsmf_pkg::IDX_W-1:0] pattern_index;
	logic [fsmf_pkg::BYTE_W-1:0] data_byte;
	logic last;
	logic out_valid;
	logic out_ready;
	logic [fsmf_pkg::POS_W-1:0] match_position;
	logic found;
	logic overflow;

	search_scoreboard sb;
	bit quiet_mode;
	bit hold_output;
	logic [fsmf_pkg::BYTE_W-1:0] pattern_copy [fsmf_pkg::PATTERN_MAX];
	logic [fsmf_pkg::BYTE_W-1:0] text_buf[$];

	first_substring_match_finder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.pattern_index(pattern_index),
		.data_byte(data_byte),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.match_position(match_position),
		.found(found),
		.overflow(overflow)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin : result_sink
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_output = 1'b0;
			end
			out_ready <= quiet_mode || ($urandom_range(99) >= 20);
		end
	end

	always @(posedge clk) begin : result_monitor
		fsmf_pkg::result_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.match_position = match_position;
			seen.found = found;
			seen.overflow = overflow;
			sb.check_report(seen);
		end
	end

	task automatic send_beat(logic o, logic [fsmf_pkg::IDX_W-1:0] idx,
		logic [fsmf_pkg::BYTE_W-1:0] b, logic l);
		@(negedge clk);
		while (!quiet_mode && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		pattern_index <= idx;
		data_byte <= b;
		last <= l;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(o, idx, b, l);
	endtask

	task automatic load_pattern_byte(int unsigned idx, logic [fsmf_pkg::BYTE_W-1:0] b);
		pattern_copy[idx] = b;
		send_beat(fsmf_pkg::OP_PATTERN, idx[fsmf_pkg::IDX_W-1:0], b,
			1'($urandom_range(1)));
	endtask

	function automatic logic [fsmf_pkg::BYTE_W-1:0] pick_pattern_byte();
		if ($urandom_range(99) < 70)
			return 8'h41 + fsmf_pkg::BYTE_W'($urandom_range(2));
		return fsmf_pkg::BYTE_W'($urandom_range(255));
	endfunction

	// Mostly pattern material: whole copies, copies broken before their end, pattern bytes.
	function automatic void build_text(int unsigned n, int unsigned used);
		int unsigned r;
		int unsigned j;
		int unsigned k;
		text_buf.delete();
		while (text_buf.size() < n) begin
			r = $urandom_range(99);
			if (used == 0 || r >= 90) begin
				text_buf.push_back(fsmf_pkg::BYTE_W'($urandom_range(255)));
			end else if (r < 12) begin
				for (j = 0; j < used; j++) text_buf.push_back(pattern_copy[j]);
			end else if (r < 18) begin
				k = $urandom_range(used - 1);
				for (j = 0; j < k; j++) text_buf.push_back(pattern_copy[j]);
				text_buf.push_back(pattern_copy[k] ^ 8'h01);
			end else begin
				text_buf.push_back(pattern_copy[$urandom_range(used - 1)]);
			end
		end
	endfunction

	task automatic send_text(bit close, bit stray_writes);
		int unsigned i;
		for (i = 0; i < text_buf.size(); i++) begin
			if (stray_writes && $urandom_range(99) < 3)
				load_pattern_byte($urandom_range(fsmf_pkg::PATTERN_MAX - 1),
					pick_pattern_byte());
			send_beat(fsmf_pkg::OP_TEXT, fsmf_pkg::IDX_W'($urandom_range(31)), text_buf[i],
				close && i == text_buf.size() - 1);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [fsmf_pkg::CFG_IDX_W-1:0] idx,
		logic [fsmf_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_search(int unsigned len, int unsigned offset);
		logic [fsmf_pkg::CFG_DATA_W-1:0] word;
		settle();
		word = fsmf_pkg::CFG_DATA_W'(len);
		if ($urandom_range(3) == 0)
			word[fsmf_pkg::CFG_DATA_W-1:fsmf_pkg::LEN_W] =
				(fsmf_pkg::CFG_DATA_W-fsmf_pkg::LEN_W)'($urandom);
		cfg_write(fsmf_pkg::REG_PATTERN_LENGTH, word);
		cfg_write(fsmf_pkg::REG_START_OFFSET, offset[fsmf_pkg::CFG_DATA_W-1:0]);
	endtask

	initial begin : stimulus
		int unsigned i;
		int unsigned t;
		int unsigned r;
		int unsigned len;
		int unsigned used;
		int unsigned offset;
		int unsigned settings;
		int unsigned base;
		int unsigned forced_len [6];
		int unsigned forced_off [6];
		sb = new();
		forced_len = '{1, 32, 63, 2, 0, 5};
		forced_off = '{0, 0, 2, 65535, 7, 0};
		settings = 0;
		quiet_mode = 1'b0;
		hold_output = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = fsmf_pkg::REG_PATTERN_LENGTH;
		cfg_data = '0;
		in_valid = 1'b0;
		op = fsmf_pkg::OP_TEXT;
		pattern_index = '0;
		data_byte = '0;
		last = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < fsmf_pkg::PATTERN_MAX; i++)
			load_pattern_byte(i, fsmf_pkg::BYTE_W'($urandom_range(255)));

		// The empty pattern at reset reports position zero as found.
		text_buf = '{8'h00};
		send_text(1'b1, 1'b0);
		set_search(3, 0);
		load_pattern_byte(0, 8'h41);
		load_pattern_byte(1, 8'h42);
		load_pattern_byte(2, 8'h43);
		text_buf = '{8'h41, 8'h42, 8'h43, 8'h41, 8'h42, 8'h43};
		send_text(1'b1, 1'b0);
		set_search(3, 1);
		send_text(1'b1, 1'b0);
		set_search(3, 4);
		send_text(1'b1, 1'b0);
		// The offset moves while a text is half delivered.
		text_buf = '{8'h41, 8'h42};
		send_text(1'b0, 1'b0);
		settle();
		cfg_write(fsmf_pkg::REG_START_OFFSET, '0);
		text_buf = '{8'h43};
		send_text(1'b1, 1'b0);
		settings = 4;

		// The receiver stalls while short texts keep coming, so the input backs up.
		set_search(2, 0);
		settings++;
		hold_output = 1'b1;
		for (t = 0; t < 40; t++) begin
			build_text($urandom_range(1, 3), 2);
			send_text(1'b1, 1'b0);
		end

		base = sb.beats_seen;
		while (sb.beats_seen - base < 1100) begin
			if (settings - 5 < 6) begin
				len = forced_len[settings-5];
				offset = forced_off[settings-5];
			end else begin
				r = $urandom_range(99);
				len = (r < 10) ? 0 : (r < 20) ? 32 : (r < 28) ? $urandom_range(33, 63)
					: (r < 40) ? 1 : $urandom_range(2, 8);
				r = $urandom_range(99);
				offset = (r < 60) ? 0 : (r < 80) ? $urandom_range(1, 30)
					: (r < 90) ? 65535 : $urandom_range(65535);
			end
			set_search(len, offset);
			settings++;
			quiet_mode = (settings % 5 == 0);
			used = (len > fsmf_pkg::PATTERN_MAX) ? fsmf_pkg::PATTERN_MAX : len;
			if (used > 0 && $urandom_range(4) != 0)
				for (i = 0; i < used; i++) load_pattern_byte(i, pick_pattern_byte());
			for (t = $urandom_range(2, 6); t > 0; t--) begin
				r = $urandom_range(99);
				build_text((r < 70) ? $urandom_range(1, 16) : (r < 95) ? $urandom_range(17, 48)
					: $urandom_range(49, 100), used);
				send_text(1'b1, 1'b1);
			end
			quiet_mode = 1'b0;
		end

		settle();
		repeat (8) @(posedge clk);

		$display("Checked %0d search results from %0d input beats over %0d register settings.",
			sb.reports_checked, sb.beats_seen, settings);
		$display("Covered empty and oversized patterns, offsets up to 65535, a held result port, "
			, "and pattern rewrites in the middle of a text.");
		if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results never seen", sb.mismatches,
				sb.pending_reports.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Timed out with %0d results outstanding", sb.pending_reports.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/fsmf_pkg.sv
hdl/fsmf_cell.sv
hdl/fsmf_out_buf.sv
hdl/first_substring_match_finder.sv
verif/tb_first_substring_match_finder.sv
